@@ sv/b64d_pkg.sv @@
// Shared types, codes and character classification for the base64 stream decoder.
`timescale 1ns / 1ps

package b64d_pkg;

    // Character kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_PAD  = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    localparam logic [7:0] CHR_PAD   = 8'h3D; // '='
    localparam logic [7:0] CHR_PLUS  = 8'h2B; // '+'
    localparam logic [7:0] CHR_SLASH = 8'h2F; // '/'
    localparam logic [7:0] CHR_MINUS = 8'h2D; // '-'
    localparam logic [7:0] CHR_UNDER = 8'h5F; // '_'

    localparam logic [1:0] QUAD_LAST = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] val;
    } t_class;

    // Up to three results caused by one character
    typedef struct packed {
        logic [23:0] bytes; // first byte in the high bits
        logic [1:0]  cnt;   // number of results, 0 to 3
        logic        err;
        logic        mend;  // last result closes the message
    } t_group;

    // Map one character to its sextet
    function automatic t_class classify(input logic [7:0] c, input logic url);
        t_class r;
        r.kind = KIND_BAD;
        r.val  = 6'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            r.kind = KIND_DATA;
            r.val  = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            r.kind = KIND_DATA;
            r.val  = 6'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            r.kind = KIND_DATA;
            r.val  = 6'(c - 8'h30 + 8'd52);
        end else if (c == CHR_PAD) begin
            r.kind = KIND_PAD;
        end else if (url) begin
            if (c == CHR_MINUS) begin
                r.kind = KIND_DATA;
                r.val  = 6'd62;
            end else if (c == CHR_UNDER) begin
                r.kind = KIND_DATA;
                r.val  = 6'd63;
            end
        end else begin
            if (c == CHR_PLUS) begin
                r.kind = KIND_DATA;
                r.val  = 6'd62;
            end else if (c == CHR_SLASH) begin
                r.kind = KIND_DATA;
                r.val  = 6'd63;
            end
        end
        return r;
    endfunction

endpackage

@@ sv/base64_stream_decoder.sv @@
// Top level of the base64 stream decoder: configuration register and stream ports.
`timescale 1ns / 1ps

// Decodes base64 text, one character per input transaction, with tlast on the
// last character of a message. Characters are taken one per cycle unless the
// input stalls; a character is held in the input register, is decoded against
// the quad state, and its results land in the output buffer, which presents
// the first result. The fourth character of a quad yields up to three result
// transactions, which the output buffer issues one per cycle while i_m_tready
// is high, as the next quad's first three characters keep flowing; an error
// yields one result, after which the rest of the message is dropped. The
// output port gives one result per cycle while i_m_tready is high; the input
// stalls only when a character with results meets a buffer holding more than
// one result, or holding one that the output side does not take in that cycle.
// The alphabet register (bit 0: 0 standard, 1 URL-safe) is written through the
// configuration channel, which is always ready.

module base64_stream_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,   // url_alphabet
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] char_code
    input  logic       i_s_tlast,    // last_char
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // [7:0] byte_value
    output logic [2:0] o_m_tuser,    // [0] byte_valid, [1] error, [2] run_end
    output logic       o_m_tlast     // message_end
);
    import b64d_pkg::*;

    logic   r_url;
    logic   w_grp_valid;
    logic   w_grp_ready;
    t_group w_grp;
    logic   w_byte_valid;
    logic   w_error;
    logic   w_rend;

    assign o_cfg_ready = 1'b1;

    // Hold the alphabet select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_url <= 1'b0;
        end else if (i_cfg_valid) begin
            r_url <= i_cfg_data;
        end
    end

    b64d_decode u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_char      (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_url       (r_url),
        .o_grp_valid (w_grp_valid),
        .i_grp_ready (w_grp_ready),
        .o_grp       (w_grp)
    );

    b64d_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_grp_valid  (w_grp_valid),
        .o_grp_ready  (w_grp_ready),
        .i_grp        (w_grp),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_byte       (o_m_tdata),
        .o_byte_valid (w_byte_valid),
        .o_error      (w_error),
        .o_mend       (o_m_tlast),
        .o_rend       (w_rend)
    );

    assign o_m_tuser = {w_rend, w_error, w_byte_valid};

    // An error result carries no byte and closes the message
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> !o_m_tuser[0] && o_m_tlast && o_m_tuser[2])
        else $error("error result malformed");

    // Message end only on the last result of a transaction's run
    a_mend_rend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser[2])
        else $error("message end without run end");

    // Input stalls only behind a result group the buffer cannot take
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> w_grp_valid && !w_grp_ready)
        else $error("input stalled without cause");

    // A group is taken over pending results only when the buffer drains its final result
    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_grp_valid && w_grp_ready && o_m_tvalid |-> i_m_tready && o_m_tuser[2])
        else $error("group loaded over pending results");

endmodule

@@ sv/b64d_decode.sv @@
// Input register, quad state and per-character decode into a result group.
`timescale 1ns / 1ps

module b64d_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_char,
    input  logic            i_last,
    input  logic            i_url,
    output logic            o_grp_valid,
    input  logic            i_grp_ready,
    output b64d_pkg::t_group o_grp
);
    import b64d_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_char;
    logic        r_last;
    logic [17:0] r_store;
    logic [1:0]  r_pos;
    logic [1:0]  r_pads;
    logic        r_disc;

    logic [17:0] n_store;
    logic [1:0]  n_pos;
    logic [1:0]  n_pads;
    logic        n_disc;

    t_class      w_cls;
    t_group      w_grp;
    logic        w_bad;
    logic [1:0]  w_pads;
    logic [23:0] w_full;
    logic        w_take;

    assign w_cls = classify(r_char, i_url);

    // Decode the held character against the quad state
    always_comb begin
        w_grp   = '0;
        n_store = r_store;
        n_pos   = r_pos;
        n_pads  = r_pads;
        n_disc  = r_disc;
        w_pads  = r_pads + ((w_cls.kind == KIND_PAD) ? 2'd1 : 2'd0);
        w_full  = {r_store, w_cls.val};
        w_bad   = (w_cls.kind == KIND_BAD)
                || (w_cls.kind == KIND_PAD && r_pos < 2'd2)
                || (w_cls.kind == KIND_DATA && r_pads != 2'd0)
                || (r_last && r_pos != QUAD_LAST)
                || (r_pos == QUAD_LAST && !r_last
                    && (r_pads != 2'd0 || w_cls.kind == KIND_PAD));
        if (r_disc) begin
            // drop until the last character of the message
            if (r_last) begin
                n_disc  = 1'b0;
                n_store = '0;
                n_pos   = '0;
                n_pads  = '0;
            end
        end else if (w_bad) begin
            w_grp.cnt  = 2'd1;
            w_grp.err  = 1'b1;
            w_grp.mend = 1'b1;
            n_disc     = !r_last;
            n_store    = '0;
            n_pos      = '0;
            n_pads     = '0;
        end else if (r_pos != QUAD_LAST) begin
            n_store = {r_store[11:0], w_cls.val};
            n_pos   = r_pos + 2'd1;
            n_pads  = w_pads;
        end else begin
            w_grp.bytes = w_full;
            w_grp.cnt   = (w_pads >= 2'd2) ? 2'd1 : 2'd3 - w_pads;
            w_grp.mend  = r_last;
            n_store     = '0;
            n_pos       = '0;
            n_pads      = '0;
        end
    end

    assign o_grp       = w_grp;
    assign o_grp_valid = r_in_valid && (w_grp.cnt != 2'd0);
    assign w_take      = r_in_valid && ((w_grp.cnt == 2'd0) || i_grp_ready);
    assign o_ready     = !r_in_valid || w_take;

    // Hold the incoming character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_char <= i_char;
            r_last <= i_last;
        end
    end

    // Advance the quad state when the character is retired
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
            r_pos   <= '0;
            r_pads  <= '0;
            r_disc  <= 1'b0;
        end else if (w_take) begin
            r_store <= n_store;
            r_pos   <= n_pos;
            r_pads  <= n_pads;
            r_disc  <= n_disc;
        end
    end

endmodule

@@ sv/b64d_out.sv @@
// Result buffer that drains one result group a result per cycle while the output is ready.
`timescale 1ns / 1ps

module b64d_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_grp_valid,
    output logic             o_grp_ready,
    input  b64d_pkg::t_group i_grp,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_byte,
    output logic             o_byte_valid,
    output logic             o_error,
    output logic             o_mend,
    output logic             o_rend
);
    import b64d_pkg::*;

    logic [23:0] r_bytes;
    logic [1:0]  r_left;
    logic        r_err;
    logic        r_mend;

    assign o_valid      = (r_left != 2'd0);
    assign o_grp_ready  = (r_left == 2'd0) || (r_left == 2'd1 && i_ready);
    assign o_byte       = r_bytes[23:16];
    assign o_byte_valid = !r_err;
    assign o_error      = r_err;
    assign o_rend       = (r_left == 2'd1);
    assign o_mend       = (r_left == 2'd1) && r_mend;

    // Load a new group or shift out the presented result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_grp_valid && o_grp_ready) begin
            r_left <= i_grp.cnt;
        end else if (o_valid && i_ready) begin
            r_left <= r_left - 2'd1;
        end
        if (i_grp_valid && o_grp_ready) begin
            r_bytes <= i_grp.bytes;
            r_err   <= i_grp.err;
            r_mend  <= i_grp.mend;
        end else if (o_valid && i_ready) begin
            r_bytes <= {r_bytes[15:0], 8'd0};
        end
    end

endmodule

@@ test/b64d_stream_checker.sv @@
// Checker for the base64 stream decoder: watches the channels, predicts decoded bytes and compares.
`timescale 1ns / 1ps

module b64d_stream_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic       i_cfg_data,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_s_tlast,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,
    input  logic [2:0] i_m_tuser,
    input  logic       i_m_tlast,
    output int         o_mismatches,
    output int         o_pending
);
    import b64d_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       valid;
        logic       err;
        logic       msg_end;
        logic       run_end;
    } t_decoded;

    t_decoded    decoded_q[$];
    int          mismatch_cnt = 0;
    int          result_cnt   = 0;

    // Shadow decoder state
    logic        url_sel;
    logic [17:0] sextets;
    logic [1:0]  quad_pos;
    logic [1:0]  pad_cnt;
    logic        dropping;

    assign o_mismatches = mismatch_cnt;
    assign o_pending    = decoded_q.size();

    task automatic clear_quad();
        sextets  = '0;
        quad_pos = '0;
        pad_cnt  = '0;
    endtask

    // Advance the shadow decoder by one character and queue what it yields
    task automatic decode_char(input logic [7:0] c, input logic last);
        logic [1:0]  kind;
        logic [5:0]  sx;
        logic [1:0]  pos;
        logic [1:0]  pads;
        logic        bad;
        logic [23:0] word;
        int          nbytes;
        t_decoded    r;
        if (dropping) begin
            if (last) begin
                dropping = 1'b0;
                clear_quad();
            end
            return;
        end
        // Map the character to its sextet
        kind = KIND_BAD;
        sx   = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin          // upper case
            kind = KIND_DATA;
            sx   = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin // lower case
            kind = KIND_DATA;
            sx   = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin // digits
            kind = KIND_DATA;
            sx   = 6'(c - 8'h30 + 8'd52);
        end else if (c == CHR_PAD) begin
            kind = KIND_PAD;
        end else if (c == (url_sel ? CHR_MINUS : CHR_PLUS)) begin
            kind = KIND_DATA;
            sx   = 6'd62;
        end else if (c == (url_sel ? CHR_UNDER : CHR_SLASH)) begin
            kind = KIND_DATA;
            sx   = 6'd63;
        end
        pos  = quad_pos;
        pads = pad_cnt;
        bad  = (kind == KIND_BAD);
        if (kind == KIND_PAD && pos < 2) bad = 1'b1;
        if (kind == KIND_DATA && pads != 0) bad = 1'b1;
        if (last && pos != QUAD_LAST) bad = 1'b1;
        if (pos == QUAD_LAST && !last && (pads != 0 || kind == KIND_PAD)) bad = 1'b1;
        // Report the error once, then drop the rest of the message
        if (bad) begin
            clear_quad();
            if (!last) dropping = 1'b1;
            r = '{value: 8'h00, valid: 1'b0, err: 1'b1, msg_end: 1'b1, run_end: 1'b1};
            decoded_q.push_back(r);
            return;
        end
        if (kind == KIND_PAD) pads = pads + 2'd1;
        if (pos != QUAD_LAST) begin
            sextets  = {sextets[11:0], sx};
            quad_pos = pos + 2'd1;
            pad_cnt  = pads;
            return;
        end
        // Quad complete: emit three bytes minus one per pad
        word   = {sextets, sx};
        nbytes = 3 - int'(pads);
        for (int i = 0; i < nbytes; i++) begin
            r.value   = word[23 - 8 * i -: 8];
            r.valid   = 1'b1;
            r.err     = 1'b0;
            r.run_end = (i == nbytes - 1);
            r.msg_end = r.run_end & last;
            decoded_q.push_back(r);
        end
        clear_quad();
    endtask

    always @(posedge i_clk) begin
        t_decoded want;
        t_decoded got;
        if (!i_rst_n) begin
            url_sel  = 1'b0;
            dropping = 1'b0;
            clear_quad();
            decoded_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) url_sel = i_cfg_data;
            if (i_s_tvalid && i_s_tready) decode_char(i_s_tdata, i_s_tlast);
            // Compare each output transaction with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got = '{value: i_m_tdata, valid: i_m_tuser[0], err: i_m_tuser[1],
                        msg_end: i_m_tlast, run_end: i_m_tuser[2]};
                if (decoded_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected result %0d: byte %h valid %b err %b mend %b rend %b",
                                 $realtime, result_cnt, got.value, got.valid, got.err,
                                 got.msg_end, got.run_end);
                end else begin
                    want = decoded_q.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"%0t: result %0d: expected byte %h valid %b err %b mend %b ",
                                      "rend %b, got byte %h valid %b err %b mend %b rend %b"},
                                     $realtime, result_cnt, want.value, want.valid, want.err,
                                     want.msg_end, want.run_end, got.value, got.valid, got.err,
                                     got.msg_end, got.run_end);
                    end
                end
                result_cnt++;
            end
        end
    end

endmodule

@@ test/testbench.sv @@
// Top of the base64 stream decoder test: clock, reset, stimulus, back pressure and verdict.
`timescale 1ns / 1ps

module testbench;
    import b64d_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_CHARS  = 45;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;
    logic       i_s_tlast;
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;
    logic [2:0] o_m_tuser;
    logic       o_m_tlast;

    int         mismatch_cnt;
    int         pending_cnt;
    int         cycle_cnt;
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    logic       hold_req      = 1'b0;
    logic [7:0] msg_q[$];

    base64_stream_decoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    b64d_stream_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_mismatches (mismatch_cnt),
        .o_pending    (pending_cnt)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // End the run if it hangs
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Output side: random stalls, plus one long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Character for a sextet in the selected alphabet
    function automatic logic [7:0] sextet_char(input int v, input logic url);
        if (v < 26) return 8'(8'h41 + v);
        if (v < 52) return 8'(8'h61 + v - 26);
        if (v < 62) return 8'(8'h30 + v - 52);
        if (v == 62) return url ? CHR_MINUS : CHR_PLUS;
        return url ? CHR_UNDER : CHR_SLASH;
    endfunction

    // Offer one character and hold it until the transaction completes
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic send_msg();
        for (int i = 0; i < msg_q.size(); i++)
            send_char(msg_q[i], i == msg_q.size() - 1);
        msg_q.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            msg_q.push_back(8'(s[i]));
        send_msg();
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_cnt != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_alphabet(input logic url);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= url;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Build one message: mostly well-formed text, some broken, some noise
    task automatic build_random_msg(input logic url);
        int roll;
        int nq;
        int pads;
        int pos;
        roll = $urandom_range(99);
        if (roll < 10) begin
            repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            nq = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
            repeat (4 * nq) msg_q.push_back(sextet_char($urandom_range(0, 63), url));
            pads = $urandom_range(0, 2);
            for (int i = 0; i < pads; i++) msg_q[msg_q.size() - 1 - i] = CHR_PAD;
            if (roll >= 78) begin
                pos = $urandom_range(0, msg_q.size() - 1);
                case ($urandom_range(0, 3))
                    0: msg_q[pos] = 8'($urandom_range(0, 255));
                    1: repeat ($urandom_range(1, 3)) void'(msg_q.pop_back());
                    2: msg_q[pos] = CHR_PAD;
                    default: begin
                        // swap in a symbol of the other alphabet
                        msg_q[pos] = $urandom_range(1) ? (url ? CHR_PLUS : CHR_MINUS)
                                                       : (url ? CHR_SLASH : CHR_UNDER);
                    end
                endcase
            end
        end
    endtask

    initial begin
        int sent;
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 76, 0, 33};
        stall_tab = '{0, 0, 76, 33};
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = 8'h00;
        i_s_tlast   = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: standard alphabet
        write_alphabet(1'b0);
        send_text("+/9z");          // both high symbols, three bytes
        send_text("QR==");          // one byte, nonzero trailing bits ignored
        msg_q.push_back(8'h00);     // bad character on the last flag
        send_msg();
        send_text("=AAA");          // pad in first position, rest dropped
        send_text("QQ=A");          // data after pad
        send_text("QUI=A");         // padded quad that is not the last one
        msg_q.push_back(8'hFF);     // bad character, all bits set
        send_msg();
        send_text("=");             // lone pad: misplaced and bad length
        send_text("AB");            // bad length
        wait_idle();

        // Directed: URL alphabet
        write_alphabet(1'b1);
        send_text("-_AA");
        send_text("+");             // symbol of the other alphabet
        wait_idle();

        // Random phases with changing idling, output stalls and alphabet
        for (int ph = 0; ph < 4; ph++) begin
            write_alphabet(ph[0]);
            send_idle_pct = idle_tab[ph];
            stall_pct     = stall_tab[ph];
            if (ph == 0) hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_CHARS) begin
                build_random_msg(ph[0]);
                sent += msg_q.size();
                send_msg();
            end
            wait_idle();
        end

        if (pending_cnt != 0)
            $display("%0d expected results never arrived", pending_cnt);
        if (mismatch_cnt == 0 && pending_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
sv/b64d_pkg.sv
sv/b64d_decode.sv
sv/b64d_out.sv
sv/base64_stream_decoder.sv
test/b64d_stream_checker.sv
test/testbench.sv
